// ===== hw/rtl/pan_tilt_stepper_tracker_defines.svh =====
// Assertion macros shared by the pan-tilt stepper tracker RTL.
`ifndef PAN_TILT_STEPPER_TRACKER_DEFINES_SVH
`define PAN_TILT_STEPPER_TRACKER_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Implication or plain property, checked out of reset.
`define PTS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never be seen.
`define PTS_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define PTS_ASSERT(lbl, clk, rst_n, prop, msg)
`define PTS_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

// ===== hw/rtl/pts_pkg.sv =====
// Types and constants of the pan-tilt stepper tracker.
package pts_pkg;

    localparam int ADDR_W = 4;

    localparam logic [7:0] CH_N    = 8'd78;
    localparam logic [7:0] CH_FIRE = 8'd49;
    localparam logic [7:0] CH_NULL = 8'd48;
    localparam logic [7:0] CH_L    = 8'd76;
    localparam logic [7:0] CH_R    = 8'd82;
    localparam logic [7:0] CH_U    = 8'd85;
    localparam logic [7:0] CH_D    = 8'd68;

    localparam logic [7:0] MOVE_PHASE_END_RST = 8'd50;
    localparam logic [7:0] PHASE_PERIOD_RST   = 8'd100;
    localparam logic [6:0] SCAN_LIMIT_RST     = 7'd50;

    typedef enum logic [1:0] {
        REG_MOVE_PHASE_END = 2'd0,
        REG_PHASE_PERIOD   = 2'd1,
        REG_SCAN_LIMIT     = 2'd2,
        REG_NONE           = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [7:0] move_phase_end;
        logic [7:0] phase_period;
        logic [6:0] scan_limit;
    } t_cfg;

    typedef struct packed {
        logic       cmd;
        logic [7:0] target_char;
        logic [7:0] horz_char;
        logic [7:0] vert_char;
    } t_item;

    typedef struct packed {
        logic horz_step;
        logic horz_dir;
        logic vert_step;
        logic vert_dir;
        logic trigger_level;
    } t_pins;

endpackage

// ===== hw/rtl/pts_item_if.sv =====
// Input item channel: tick or command with three characters.
interface pts_item_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] target_char;
    logic [7:0] horz_char;
    logic [7:0] vert_char;

    modport source (output valid, cmd, target_char, horz_char, vert_char, input ready);
    modport sink   (input valid, cmd, target_char, horz_char, vert_char, output ready);
endinterface

// ===== hw/rtl/pts_result_if.sv =====
// Result item channel: pin levels for one tick.
interface pts_result_if;
    logic valid;
    logic ready;
    logic horz_step;
    logic horz_dir;
    logic vert_step;
    logic vert_dir;
    logic trigger_level;

    modport source (output valid, horz_step, horz_dir, vert_step, vert_dir, trigger_level,
                    input ready);
    modport sink   (input valid, horz_step, horz_dir, vert_step, vert_dir, trigger_level,
                    output ready);
endinterface

// ===== hw/rtl/pts_cfg.sv =====
// APB configuration registers of the tracker.
module pts_cfg
    import pts_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.move_phase_end <= MOVE_PHASE_END_RST;
            r_cfg.phase_period   <= PHASE_PERIOD_RST;
            r_cfg.scan_limit     <= SCAN_LIMIT_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_MOVE_PHASE_END: r_cfg.move_phase_end <= pwdata[7:0];
                REG_PHASE_PERIOD:   r_cfg.phase_period   <= pwdata[7:0];
                REG_SCAN_LIMIT:     r_cfg.scan_limit     <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_MOVE_PHASE_END: prdata = {24'd0, r_cfg.move_phase_end};
            REG_PHASE_PERIOD:   prdata = {24'd0, r_cfg.phase_period};
            REG_SCAN_LIMIT:     prdata = {25'd0, r_cfg.scan_limit};
            default:            prdata = '0;
        endcase
    end

endmodule

// ===== hw/rtl/pts_core.sv =====
// Phase counter, latched command and motion decision of the tracker.
`include "pan_tilt_stepper_tracker_defines.svh"
module pts_core
    import pts_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_go,
    input  t_item i_item,
    input  t_cfg  i_cfg,
    output t_pins o_pins
);

    logic [7:0]        r_phase, n_phase;
    logic [7:0]        r_scan_pos, n_scan_pos;
    logic              r_horz_dir, n_horz_dir;
    logic              r_vert_dir, n_vert_dir;
    logic              r_horz_mov, n_horz_mov;
    logic              r_vert_mov, n_vert_mov;
    logic              r_trig_idle, n_trig_idle;
    logic [7:0]        r_lat_t, n_lat_t;
    logic [7:0]        r_lat_h, n_lat_h;
    logic [7:0]        r_lat_v, n_lat_v;

    logic              w_above;
    logic [8:0]        w_next9;
    logic              w_restart;
    logic              w_fire;
    logic              w_track;
    logic              w_null;
    logic signed [8:0] w_pos9;
    logic signed [8:0] w_lim9;
    logic signed [8:0] w_pos_c;
    logic signed [8:0] w_pos_n;
    logic              w_scan_dir;

    assign w_above   = r_phase > i_cfg.move_phase_end;
    assign w_next9   = {1'b0, r_phase} + 9'd1;
    assign w_restart = w_above && (w_next9 >= {1'b0, i_cfg.phase_period});
    assign w_fire    = r_lat_t == CH_FIRE;
    assign w_track   = (r_lat_h != CH_N) || (r_lat_v != CH_N);
    assign w_null    = (i_item.target_char == CH_NULL) || (i_item.horz_char == CH_NULL)
                    || (i_item.vert_char == CH_NULL);
    assign w_pos9    = {r_scan_pos[7], r_scan_pos};
    assign w_lim9    = {2'b00, i_cfg.scan_limit};

    // Clamp to the scan window, then step one in the resulting direction.
    always_comb begin
        w_pos_c    = w_pos9;
        w_scan_dir = r_horz_dir;
        if (w_pos_c > w_lim9) begin
            w_pos_c    = w_lim9;
            w_scan_dir = 1'b0;
        end
        if (w_pos_c < -w_lim9) begin
            w_pos_c    = -w_lim9;
            w_scan_dir = 1'b1;
        end
        w_pos_n = w_scan_dir ? w_pos_c + 9'sd1 : w_pos_c - 9'sd1;
    end

    // Pins reflect the state before the tick updates it.
    always_comb begin
        o_pins.horz_step     = w_above ? 1'b0 : r_horz_mov;
        o_pins.horz_dir      = r_horz_dir;
        o_pins.vert_step     = w_above ? 1'b0 : r_vert_mov;
        o_pins.vert_dir      = r_vert_dir;
        o_pins.trigger_level = r_trig_idle;
    end

    always_comb begin
        n_phase     = r_phase;
        n_scan_pos  = r_scan_pos;
        n_horz_dir  = r_horz_dir;
        n_vert_dir  = r_vert_dir;
        n_horz_mov  = r_horz_mov;
        n_vert_mov  = r_vert_mov;
        n_trig_idle = r_trig_idle;
        n_lat_t     = r_lat_t;
        n_lat_h     = r_lat_h;
        n_lat_v     = r_lat_v;
        if (i_go) begin
            if (i_item.cmd) begin
                if (w_null) begin
                    n_lat_t = CH_N;
                    n_lat_h = CH_N;
                    n_lat_v = CH_N;
                end else begin
                    n_lat_t = i_item.target_char;
                    n_lat_h = i_item.horz_char;
                    n_lat_v = i_item.vert_char;
                end
            end else if (!w_above) begin
                n_phase = r_phase + 8'd1;
            end else if (!w_restart) begin
                n_phase = w_next9[7:0];
            end else begin
                n_phase = '0;
                priority if (w_fire) begin
                    n_trig_idle = 1'b0;
                    n_horz_mov  = 1'b0;
                    n_vert_mov  = 1'b0;
                end else if (w_track) begin
                    n_trig_idle = 1'b1;
                    n_horz_mov  = r_lat_h != CH_N;
                    n_vert_mov  = r_lat_v != CH_N;
                    if (r_lat_h == CH_L) begin
                        n_horz_dir = 1'b0;
                    end else if (r_lat_h == CH_R) begin
                        n_horz_dir = 1'b1;
                    end
                    if (r_lat_v == CH_U) begin
                        n_vert_dir = 1'b0;
                    end else if (r_lat_v == CH_D) begin
                        n_vert_dir = 1'b1;
                    end
                end else begin
                    n_trig_idle = 1'b1;
                    n_horz_mov  = 1'b1;
                    n_horz_dir  = w_scan_dir;
                    n_scan_pos  = w_pos_n[7:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= '0;
            r_scan_pos  <= '0;
            r_horz_dir  <= 1'b0;
            r_vert_dir  <= 1'b0;
            r_horz_mov  <= 1'b0;
            r_vert_mov  <= 1'b0;
            r_trig_idle <= 1'b1;
            r_lat_t     <= CH_N;
            r_lat_h     <= CH_N;
            r_lat_v     <= CH_N;
        end else begin
            r_phase     <= n_phase;
            r_scan_pos  <= n_scan_pos;
            r_horz_dir  <= n_horz_dir;
            r_vert_dir  <= n_vert_dir;
            r_horz_mov  <= n_horz_mov;
            r_vert_mov  <= n_vert_mov;
            r_trig_idle <= n_trig_idle;
            r_lat_t     <= n_lat_t;
            r_lat_h     <= n_lat_h;
            r_lat_v     <= n_lat_v;
        end
    end

    `PTS_ASSERT(a_restart_clears_phase, i_clk, i_rst_n, i_go && !i_item.cmd && w_restart |=> r_phase == 8'd0, "phase not cleared at period end")
    `PTS_ASSERT(a_fire_stops_axes, i_clk, i_rst_n, i_go && !i_item.cmd && w_restart && w_fire |=> !r_horz_mov && !r_vert_mov && !r_trig_idle, "fire decision left an axis moving")
    `PTS_NEVER(a_no_null_latched, i_clk, i_rst_n, r_lat_t == CH_NULL || r_lat_h == CH_NULL || r_lat_v == CH_NULL, "null character latched")
    `PTS_ASSERT(a_cmd_keeps_pins, i_clk, i_rst_n, i_go && i_item.cmd |=> $stable(r_phase) && $stable(r_horz_mov) && $stable(r_trig_idle), "command item changed motion state")

endmodule

// ===== hw/rtl/pan_tilt_stepper_tracker.sv =====
// An accepted item is held in the item register until it moves on; its result is then registered.
// Throughput: one item per cycle while no tick waits on the result register; a command item gives no result.
// A tick waits while an undrained result sits in the result register; input stalls behind it.
// Each tick updates the phase counter and, at the end of a period, makes one compare-and-clamp decision.
// Reset (i_rst_n low, synchronous) empties both registers and restores state and registers.
// Top level of the pan-tilt stepper tracker.
module pan_tilt_stepper_tracker
    import pts_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    pts_item_if.sink          i_item,
    pts_result_if.source      o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    t_cfg  w_cfg;
    t_pins w_pins;
    t_item r_item;
    logic  r_item_valid;
    t_pins r_pins;
    logic  r_out_valid;
    logic  w_advance;
    logic  w_in_take;

    pts_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    pts_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (w_advance),
        .i_item  (r_item),
        .i_cfg   (w_cfg),
        .o_pins  (w_pins)
    );

    // A held item moves on when it is a command or the result register has room.
    assign w_advance    = r_item_valid && (r_item.cmd || !r_out_valid || o_result.ready);
    assign i_item.ready = !r_item_valid || w_advance;
    assign w_in_take    = i_item.valid && i_item.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_item_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_item.cmd         <= i_item.cmd;
            r_item.target_char <= i_item.target_char;
            r_item.horz_char   <= i_item.horz_char;
            r_item.vert_char   <= i_item.vert_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && !r_item.cmd) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && !r_item.cmd) begin
            r_pins <= w_pins;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.horz_step     = r_pins.horz_step;
    assign o_result.horz_dir      = r_pins.horz_dir;
    assign o_result.vert_step     = r_pins.vert_step;
    assign o_result.vert_dir      = r_pins.vert_dir;
    assign o_result.trigger_level = r_pins.trigger_level;

endmodule
